// ===== rtl/ffpa_pkg.sv =====
`default_nettype none

package ffpa_pkg;

    // field widths
    localparam int KIND_W      = 2;
    localparam int SIZE_W      = 17;
    localparam int PAGE_W      = 9;
    localparam int STATUS_W    = 2;
    localparam int MARK_W      = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RUN    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    // page map marks
    localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_HEAD = 2'd1;
    localparam logic [MARK_W-1:0] MARK_CONT = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/ffpa_ram.sv =====
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/first_fit_page_allocator.sv =====
`default_nettype none

// channel   direction  tdata (low bit up)                         tuser
// s_axis    in         size_bytes[16:0], page_number[25:17], pad   kind[1:0]
// m_axis    out        head_page[8:0], pad                         status[1:0]
//
// allocate: the map is scanned one entry per cycle through the single read port of
//   the map ram, then the run is marked one entry per cycle through its write
//   port
// free: a page out of range is rejected as invalid, an unmarked head page answers
//   not allocated, else the head and each continuation page after it are written free
// clear: every map entry is written free, then an ok result is given
// reset: a sweep writes every map entry free, no item taken
// s_axis_tready is high only while the block is idle; a result that m_axis does
//   not take holds in the output register while the next item is accepted

module first_fit_page_allocator #(
    parameter int NUM_PAGES  = 256,
    parameter int PAGE_BYTES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // size_bytes[16:0], page_number[25:17], zeros above
    input  logic [ffpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[1:0]
    input  logic [ffpa_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // head_page[8:0], zeros above
    output logic [ffpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [ffpa_pkg::STATUS_W-1:0]       m_axis_tuser
);

    import ffpa_pkg::*;

    localparam int AW          = $clog2(NUM_PAGES);
    localparam int TOTAL_BYTES = NUM_PAGES * PAGE_BYTES;
    localparam int RB_W        = $clog2(TOTAL_BYTES + 1);
    localparam int CMP_W       = (RB_W > SIZE_W) ? RB_W : SIZE_W;
    localparam logic [AW-1:0]    LAST   = AW'(NUM_PAGES - 1);
    localparam logic [CMP_W-1:0] PB_INC = CMP_W'(PAGE_BYTES);

    typedef enum logic [6:0] {
        S_CLEAR     = 7'b0000001,
        S_IDLE      = 7'b0000010,
        S_SCAN      = 7'b0000100,
        S_MARK      = 7'b0001000,
        S_FREE_HD   = 7'b0010000,
        S_FREE_WALK = 7'b0100000,
        S_RESP      = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_start, n_start;
    logic [AW-1:0]        r_end, n_end;
    logic [CMP_W-1:0]     r_rb, n_rb;
    logic [SIZE_W-1:0]    r_size, n_size;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [PAGE_W-1:0]    r_res_page, n_res_page;
    logic                 r_clr_resp, n_clr_resp;
    logic                 r_m_valid, n_m_valid;
    logic [STATUS_W-1:0]  r_m_status, n_m_status;
    logic [PAGE_W-1:0]    r_m_page, n_m_page;

    logic [SIZE_W-1:0]    in_size;
    logic [PAGE_W-1:0]    in_page;
    logic [AW-1:0]        in_idx;
    logic                 page_bad;
    logic [AW-1:0]        ptr_next;
    logic                 at_last;
    logic [CMP_W-1:0]     rb_sum;
    logic                 run_hit;
    logic [AW:0]          start_p1;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MARK_W-1:0]    wr_data;
    logic [AW-1:0]        rd_addr;
    logic [MARK_W-1:0]    rd_data;

    assign in_size  = s_axis_tdata[SIZE_W-1:0];
    assign in_page  = s_axis_tdata[SIZE_W +: PAGE_W];
    // page p lives in map entry p-1
    assign in_idx   = AW'(in_page - PAGE_W'(1));
    assign page_bad = (in_page == '0) || (32'(in_page) > 32'(NUM_PAGES));

    assign at_last  = (r_ptr == LAST);
    assign ptr_next = at_last ? r_ptr : r_ptr + AW'(1);
    // bytes covered by the current free run if this entry joins it
    assign rb_sum   = r_rb + PB_INC;
    assign run_hit  = (rb_sum >= CMP_W'(r_size));
    assign start_p1 = {1'b0, r_start} + {{AW{1'b0}}, 1'b1};

    // read one entry ahead: the data arriving each cycle belongs to r_ptr
    assign rd_addr = (r_state == S_IDLE) ?
                     ((s_axis_tuser == KIND_FREE) ? in_idx : '0) : ptr_next;

    ffpa_ram #(
        .WIDTH (MARK_W),
        .DEPTH (NUM_PAGES)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_start    = r_start;
        n_end      = r_end;
        n_rb       = r_rb;
        n_size     = r_size;
        n_page     = r_page;
        n_status   = r_status;
        n_res_page = r_res_page;
        n_clr_resp = r_clr_resp;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_page   = r_m_page;
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_data    = MARK_FREE;

        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (at_last) begin
                    if (r_clr_resp) begin
                        n_status   = ST_OK;
                        n_res_page = '0;
                        n_state    = S_RESP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        KIND_ALLOC: begin
                            if (in_size == '0) begin
                                n_status   = ST_INVALID;
                                n_res_page = '0;
                                n_state    = S_RESP;
                            end else begin
                                n_size  = in_size;
                                n_rb    = '0;
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_FREE: begin
                            if (page_bad) begin
                                n_status   = ST_INVALID;
                                n_res_page = '0;
                                n_state    = S_RESP;
                            end else begin
                                n_ptr   = in_idx;
                                n_page  = in_page;
                                n_state = S_FREE_HD;
                            end
                        end
                        KIND_CLEAR: begin
                            n_ptr      = '0;
                            n_clr_resp = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_status   = ST_INVALID;
                            n_res_page = '0;
                            n_state    = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_data == MARK_FREE && run_hit) begin
                    // run long enough: mark from its head up to this entry
                    n_end   = r_ptr;
                    n_start = (r_rb == '0) ? r_ptr : r_start;
                    n_ptr   = (r_rb == '0) ? r_ptr : r_start;
                    n_state = S_MARK;
                end else begin
                    if (rd_data == MARK_FREE) begin
                        n_rb = rb_sum;
                        if (r_rb == '0) begin
                            n_start = r_ptr;
                        end
                    end else begin
                        n_rb = '0;
                    end
                    if (at_last) begin
                        n_status   = ST_NO_RUN;
                        n_res_page = '0;
                        n_state    = S_RESP;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
            end
            S_MARK: begin
                wr_en   = 1'b1;
                wr_data = (r_ptr == r_start) ? MARK_HEAD : MARK_CONT;
                if (r_ptr == r_end) begin
                    n_status   = ST_OK;
                    n_res_page = PAGE_W'(start_p1);
                    n_state    = S_RESP;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_FREE_HD: begin
                if (rd_data == MARK_FREE) begin
                    n_status   = ST_NOT_ALLOC;
                    n_res_page = '0;
                    n_state    = S_RESP;
                end else begin
                    wr_en = 1'b1;
                    if (at_last) begin
                        n_status   = ST_OK;
                        n_res_page = r_page;
                        n_state    = S_RESP;
                    end else begin
                        n_ptr   = r_ptr + AW'(1);
                        n_state = S_FREE_WALK;
                    end
                end
            end
            S_FREE_WALK: begin
                // write to r_ptr while the read runs one entry ahead
                if (rd_data == MARK_CONT) begin
                    wr_en = 1'b1;
                    if (at_last) begin
                        n_status   = ST_OK;
                        n_res_page = r_page;
                        n_state    = S_RESP;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end else begin
                    n_status   = ST_OK;
                    n_res_page = r_page;
                    n_state    = S_RESP;
                end
            end
            S_RESP: begin
                // wait for the output register to be free or draining
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_page   = r_res_page;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ptr      <= '0;
            r_clr_resp <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_clr_resp <= n_clr_resp;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_end      <= n_end;
        r_rb       <= n_rb;
        r_size     <= n_size;
        r_page     <= n_page;
        r_status   <= n_status;
        r_res_page <= n_res_page;
        r_m_status <= n_m_status;
        r_m_page   <= n_m_page;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - PAGE_W){1'b0}}, r_m_page};
    assign m_axis_tuser  = r_m_status;

endmodule

`default_nettype wire

// ===== rtl/ffpa_checker.sv =====
`default_nettype none

module ffpa_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    input  wire                                s_axis_tready,
    input  wire [ffpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire [ffpa_pkg::KIND_W-1:0]         s_axis_tuser,
    input  wire                                m_axis_tvalid,
    input  wire                                m_axis_tready,
    input  wire [ffpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire [ffpa_pkg::STATUS_W-1:0]       m_axis_tuser
);

    import ffpa_pkg::*;

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                    && (s_axis_tuser == s_axis_tuser);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a failed request never names a page other than zero (a clear answers ok with page zero)
    a_fail_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("failure result carries a page");

    // one item at a time: ready drops after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("item accepted while previous still in work");

    // reset empties the output and starts the map sweep
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("block not quiet after reset");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
